// ===== rtl/core/wsp_pkg.sv =====
// Shared widths, constants and types for the world-to-screen projection pipeline.
// No dependencies; imported by every module under rtl/core.
package wsp_pkg;

   localparam int CoordW   = 32;
   localparam int ProdW    = 48;
   localparam int ClipW    = 50;
   localparam int SizeW    = 14;
   localparam int HalfW    = SizeW + 15;
   localparam int MagSplit = 25;
   localparam int PartW    = MagSplit + HalfW;
   localparam int NumW     = 78;
   localparam int QuotW    = 40;
   localparam int DivW     = 49;
   localparam int TermW    = QuotW + 2;
   localparam int WMinRaw  = 656;

   localparam int DotLat   = 2;
   localparam int ScaleLat = 3;
   localparam int DivLat   = QuotW + 1;
   localparam int PipeLat  = DotLat + ScaleLat + DivLat + 1;

   typedef enum logic [2:0] {
      CSR_ROW0_A, CSR_ROW0_B, CSR_ROW1_A, CSR_ROW1_B,
      CSR_ROW3_A, CSR_ROW3_B, CSR_WIDTH, CSR_HEIGHT
   } csr_index_type;

   typedef struct packed {
      logic             neg;
      logic [QuotW:0]   mag;
   } quot_type;

endpackage

// ===== rtl/core/wsp_dot.sv =====
// Two-stage dot product of one matrix row with (x, y, z, 1), products floored to Q16.16.
// Depends on wsp_pkg.
module wsp_dot import wsp_pkg::*; (
   input  logic                     clock,
   input  logic                     en,
   input  logic signed [CoordW-1:0] x,
   input  logic signed [CoordW-1:0] y,
   input  logic signed [CoordW-1:0] z,
   input  logic [63:0]              pair_a,
   input  logic [63:0]              pair_b,
   output logic signed [ClipW-1:0]  clip
);

   logic signed [2*CoordW-1:0] px, py, pz;
   logic signed [ProdW-1:0]    px_ff, py_ff, pz_ff;
   logic signed [CoordW-1:0]   trans_ff;
   logic signed [ClipW-1:0]    clip_ff, clip_in;

   assign px = $signed(pair_a[31:0])  * x;
   assign py = $signed(pair_a[63:32]) * y;
   assign pz = $signed(pair_b[31:0])  * z;

   assign clip_in = ClipW'(px_ff) + ClipW'(py_ff) + ClipW'(pz_ff) + ClipW'(trans_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff    <= px[2*CoordW-1:16];
         py_ff    <= py[2*CoordW-1:16];
         pz_ff    <= pz[2*CoordW-1:16];
         trans_ff <= $signed(pair_b[63:32]);
         clip_ff  <= clip_in;
      end
   end

   assign clip = clip_ff;

endmodule

// ===== rtl/core/wsp_scale.sv =====
// Three-stage magnitude and scale: |clip| times half viewport size, split into two products.
// Depends on wsp_pkg.
module wsp_scale import wsp_pkg::*; (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [ClipW-1:0] clip,
   input  logic signed [ClipW-1:0] w,
   input  logic [HalfW-1:0]        half,
   output logic [NumW-1:0]         num,
   output logic                    neg,
   output logic [DivW-1:0]         den
);

   logic [ClipW-1:0] mag_ff;
   logic [PartW-1:0] plo_ff, phi_ff;
   logic [NumW-1:0]  num_ff;
   logic             neg1_ff, neg2_ff, neg3_ff;
   logic [DivW-1:0]  den1_ff, den2_ff, den3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         neg1_ff <= clip[ClipW-1];
         mag_ff  <= clip[ClipW-1] ? ClipW'(-clip) : ClipW'(clip);
         den1_ff <= w[DivW-1:0];
         plo_ff  <= PartW'(mag_ff[MagSplit-1:0]) * PartW'(half);
         phi_ff  <= PartW'(mag_ff[ClipW-1:MagSplit]) * PartW'(half);
         neg2_ff <= neg1_ff;
         den2_ff <= den1_ff;
         num_ff  <= NumW'({phi_ff, {MagSplit{1'b0}}}) + NumW'(plo_ff);
         neg3_ff <= neg2_ff;
         den3_ff <= den2_ff;
      end
   end

   assign num = num_ff;
   assign neg = neg3_ff;
   assign den = den3_ff;

endmodule

// ===== rtl/core/wsp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, quotient clamped at 2^40.
// Depends on wsp_pkg.
module wsp_div import wsp_pkg::*; (
   input  logic            clock,
   input  logic            en,
   input  logic [NumW-1:0] num,
   input  logic            neg,
   input  logic [DivW-1:0] den,
   output quot_type        res
);

   logic [DivW-1:0]  rem_ff [0:QuotW];
   logic [QuotW-1:0] low_ff [0:QuotW];
   logic [QuotW-1:0] quo_ff [0:QuotW];
   logic [DivW-1:0]  den_ff [0:QuotW];
   logic             neg_ff [0:QuotW];
   logic             sat_ff [0:QuotW];

   logic [NumW-QuotW-1:0] head;
   assign head = num[NumW-1:QuotW];

   always_ff @(posedge clock) begin
      if (en) begin
         sat_ff[0] <= DivW'(head) >= den;
         rem_ff[0] <= DivW'(head);
         low_ff[0] <= num[QuotW-1:0];
         quo_ff[0] <= '0;
         den_ff[0] <= den;
         neg_ff[0] <= neg;
      end
   end

   for (genvar k = 1; k <= QuotW; k++) begin : g_step
      logic [DivW:0] trial;
      logic [DivW:0] diff;
      logic          ge;
      assign trial = {rem_ff[k-1], low_ff[k-1][QuotW-1]};
      assign diff  = trial - {1'b0, den_ff[k-1]};
      assign ge    = trial >= {1'b0, den_ff[k-1]};
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= ge ? diff[DivW-1:0] : trial[DivW-1:0];
            quo_ff[k] <= {quo_ff[k-1][QuotW-2:0], ge};
            low_ff[k] <= {low_ff[k-1][QuotW-2:0], 1'b0};
            den_ff[k] <= den_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
            sat_ff[k] <= sat_ff[k-1];
         end
      end
   end

   assign res.neg = neg_ff[QuotW];
   assign res.mag = sat_ff[QuotW] ? {1'b1, {QuotW{1'b0}}} : {1'b0, quo_ff[QuotW]};

endmodule

// ===== rtl/core/world_to_screen_projection.sv =====
// World-to-screen perspective projection, fully pipelined.
// Throughput one point per cycle while no result beat is stalled.
// Depth is set by the 41-stage divider (one quotient bit per stage) after dot and scale.
// The whole pipeline holds while a result beat waits and rsp_ready is low.
// Synchronous reset clears valid bits and restores matrix 0 and viewport 1920 x 1080.
module world_to_screen_projection import wsp_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [CoordW-1:0] req_world_x,
   input  logic signed [CoordW-1:0] req_world_y,
   input  logic signed [CoordW-1:0] req_world_z,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_visible,
   output logic signed [CoordW-1:0] rsp_screen_x,
   output logic signed [CoordW-1:0] rsp_screen_y,
   input  logic                     csr_we,
   input  logic [2:0]               csr_index,
   input  logic [63:0]              csr_data
);

   logic [63:0]      row0_a_ff, row0_b_ff, row1_a_ff, row1_b_ff, row3_a_ff, row3_b_ff;
   logic [SizeW-1:0] width_ff, height_ff;
   logic             en;
   logic             vld_ff [0:PipeLat-1];
   logic             vis_ff [DotLat:PipeLat-2];
   logic signed [ClipW-1:0] clip_w, clip_x, clip_y;
   logic [HalfW-1:0] half_w, half_h;
   logic [NumW-1:0]  num_x, num_y;
   logic             neg_x, neg_y;
   logic [DivW-1:0]  den_x, den_y;
   quot_type         quo_x, quo_y;
   logic             vis_out_ff;
   logic signed [CoordW-1:0] sx_ff, sy_ff, sx_in, sy_in;
   logic signed [TermW-1:0]  tx, ty;

   function automatic logic signed [CoordW-1:0] sat32(input logic signed [TermW-1:0] v);
      logic signed [TermW-1:0] hi;
      logic signed [TermW-1:0] lo;
      hi = TermW'(32'sh7FFF_FFFF);
      lo = -TermW'(33'sh0_8000_0000);
      if (v > hi) return 32'sh7FFF_FFFF;
      if (v < lo) return 32'sh8000_0000;
      return v[CoordW-1:0];
   endfunction

   assign en        = !vld_ff[PipeLat-1] || rsp_ready;
   assign req_ready = en;
   assign half_w    = {width_ff, 15'b0};
   assign half_h    = {height_ff, 15'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         row0_a_ff <= '0;
         row0_b_ff <= '0;
         row1_a_ff <= '0;
         row1_b_ff <= '0;
         row3_a_ff <= '0;
         row3_b_ff <= '0;
         width_ff  <= SizeW'(1920);
         height_ff <= SizeW'(1080);
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_ROW0_A: row0_a_ff <= csr_data;
            CSR_ROW0_B: row0_b_ff <= csr_data;
            CSR_ROW1_A: row1_a_ff <= csr_data;
            CSR_ROW1_B: row1_b_ff <= csr_data;
            CSR_ROW3_A: row3_a_ff <= csr_data;
            CSR_ROW3_B: row3_b_ff <= csr_data;
            CSR_WIDTH:  width_ff  <= csr_data[SizeW-1:0];
            CSR_HEIGHT: height_ff <= csr_data[SizeW-1:0];
            default:    row0_a_ff <= row0_a_ff;
         endcase
      end
   end

   wsp_dot u_dot_w (.clock, .en, .x(req_world_x), .y(req_world_y), .z(req_world_z),
                    .pair_a(row3_a_ff), .pair_b(row3_b_ff), .clip(clip_w));
   wsp_dot u_dot_x (.clock, .en, .x(req_world_x), .y(req_world_y), .z(req_world_z),
                    .pair_a(row0_a_ff), .pair_b(row0_b_ff), .clip(clip_x));
   wsp_dot u_dot_y (.clock, .en, .x(req_world_x), .y(req_world_y), .z(req_world_z),
                    .pair_a(row1_a_ff), .pair_b(row1_b_ff), .clip(clip_y));

   wsp_scale u_scale_x (.clock, .en, .clip(clip_x), .w(clip_w), .half(half_w),
                        .num(num_x), .neg(neg_x), .den(den_x));
   wsp_scale u_scale_y (.clock, .en, .clip(clip_y), .w(clip_w), .half(half_h),
                        .num(num_y), .neg(neg_y), .den(den_y));

   wsp_div u_div_x (.clock, .en, .num(num_x), .neg(neg_x), .den(den_x), .res(quo_x));
   wsp_div u_div_y (.clock, .en, .num(num_y), .neg(neg_y), .den(den_y), .res(quo_y));

   // advance valid bits with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PipeLat; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < PipeLat; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vis_ff[DotLat] <= clip_w >= ClipW'(WMinRaw);
         for (int i = DotLat + 1; i <= PipeLat - 2; i++) vis_ff[i] <= vis_ff[i-1];
      end
   end

   always_comb begin
      tx = quo_x.neg ? -TermW'(quo_x.mag) : TermW'(quo_x.mag);
      ty = quo_y.neg ? -TermW'(quo_y.mag) : TermW'(quo_y.mag);
      sx_in = sat32(TermW'(half_w) + tx);
      sy_in = sat32(TermW'(half_h) - ty);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vis_out_ff <= vis_ff[PipeLat-2];
         sx_ff      <= vis_ff[PipeLat-2] ? sx_in : '0;
         sy_ff      <= vis_ff[PipeLat-2] ? sy_in : '0;
      end
   end

   assign rsp_valid    = vld_ff[PipeLat-1];
   assign rsp_visible  = vis_out_ff;
   assign rsp_screen_x = sx_ff;
   assign rsp_screen_y = sy_ff;

endmodule

// ===== rtl/core/wsp_checker.sv =====
// Port-level checks for world_to_screen_projection, attached by bind.
// Depends on wsp_pkg and the top level's ports.
module wsp_checker import wsp_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic                     rsp_visible,
   input logic signed [CoordW-1:0] rsp_screen_x,
   input logic signed [CoordW-1:0] rsp_screen_y
);

   a_ready_follows_output: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("req_ready does not follow output slot");

   a_hidden_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_visible |-> rsp_screen_x == 0 && rsp_screen_y == 0)
      else $error("hidden point with nonzero screen beat");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result beat right after reset");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_screen_x) && $stable(rsp_screen_y))
      else $error("stalled result beat changed");

endmodule

bind world_to_screen_projection wsp_checker u_wsp_checker (
   .clock, .reset, .req_ready, .rsp_valid, .rsp_ready,
   .rsp_visible, .rsp_screen_x, .rsp_screen_y
);

// ===== sim/tb.sv =====
// Self-checking bench for world_to_screen_projection: random and directed points,
// predicted in place and compared beat for beat. Depends on rtl/core/wsp_pkg.sv and the top level.
`timescale 1ns / 100ps
module tb;
   import wsp_pkg::*;

   typedef struct {
      logic signed [CoordW-1:0] x, y, z;
   } world_pt_type;

   typedef struct {
      logic                     vis;
      logic signed [CoordW-1:0] sx, sy;
   } screen_pt_type;

   localparam longint QuotCap = 64'd1 << QuotW;
   localparam int     CycleLimit = 400000;
   localparam logic [31:0] One = 32'h0001_0000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [CoordW-1:0] req_world_x = '0, req_world_y = '0, req_world_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_visible;
   logic signed [CoordW-1:0] rsp_screen_x, rsp_screen_y;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_data = '0;

   logic [63:0] mat_reg [6];
   logic [SizeW-1:0] vp_w, vp_h;

   world_pt_type  point_q [$];
   screen_pt_type screen_q [$];
   int send_idle_pct = 0, recv_idle_pct = 0;
   int mismatches = 0, beats_out = 0, seen_visible = 0;
   int hold_left = 0, cycles = 0;
   bit squeeze = 1'b0, held_once = 1'b0;

   world_to_screen_projection i_dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint fx_mul(logic signed [31:0] a, logic signed [31:0] b);
      longint p;
      p = longint'(a) * longint'(b);
      return p >>> 16;
   endfunction

   function automatic longint row_dot(logic [63:0] pa, logic [63:0] pb, world_pt_type p);
      return fx_mul(pa[31:0], p.x) + fx_mul(pa[63:32], p.y) + fx_mul(pb[31:0], p.z)
           + longint'($signed(pb[63:32]));
   endfunction

   function automatic longint scaled_term(longint n, longint half, longint d);
      logic [127:0] num, q;
      longint mag;
      mag = (n < 0) ? -n : n;
      num = 128'(mag) * 128'(half);
      q = num / 128'(d);
      if (q >= 128'(QuotCap)) q = 128'(QuotCap);
      return (n < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
   endfunction

   function automatic logic [31:0] clamp32(longint v);
      if (v > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
      if (v < -64'sh8000_0000) return 32'h8000_0000;
      return v[31:0];
   endfunction

   function automatic screen_pt_type project(world_pt_type p);
      screen_pt_type r;
      longint w, cx, cy, hw, hh;
      w = row_dot(mat_reg[4], mat_reg[5], p);
      r = '{1'b0, '0, '0};
      if (w < WMinRaw) return r;
      cx = row_dot(mat_reg[0], mat_reg[1], p);
      cy = row_dot(mat_reg[2], mat_reg[3], p);
      hw = longint'(vp_w) << 15;
      hh = longint'(vp_h) << 15;
      r.vis = 1'b1;
      r.sx = clamp32(hw + scaled_term(cx, hw, w));
      r.sy = clamp32(hh - scaled_term(cy, hh, w));
      return r;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("mismatch %s at beat %0d: got %h want %h", what, beats_out, got, want);
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // driver
   always @(posedge clock) begin
      world_pt_type p;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_ready)) begin
         if (req_valid) screen_q.push_back(project('{req_world_x, req_world_y, req_world_z}));
         if (point_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            p = point_q.pop_front();
            req_valid <= 1'b1;
            req_world_x <= p.x;
            req_world_y <= p.y;
            req_world_z <= p.z;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      screen_pt_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (screen_q.size() == 0) begin
               report("unexpected beat", {31'b0, rsp_visible}, '0);
            end else begin
               e = screen_q.pop_front();
               if (rsp_visible !== e.vis) report("visible", {31'b0, rsp_visible}, {31'b0, e.vis});
               if (rsp_screen_x !== e.sx) report("screen_x", rsp_screen_x, e.sx);
               if (rsp_screen_y !== e.sy) report("screen_y", rsp_screen_y, e.sy);
               if (e.vis) seen_visible++;
            end
            beats_out++;
         end
         if (squeeze && !held_once) begin
            held_once <= 1'b1;
            hold_left <= 300;
            rsp_ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic csr_write(csr_index_type idx, logic [63:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      if (idx <= CSR_ROW3_B) mat_reg[idx] = val;
      else if (idx == CSR_WIDTH) vp_w = val[SizeW-1:0];
      else vp_h = val[SizeW-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic load_view(logic [31:0] m [12], int w, int h);
      csr_write(CSR_ROW0_A, {m[1], m[0]});
      csr_write(CSR_ROW0_B, {m[3], m[2]});
      csr_write(CSR_ROW1_A, {m[5], m[4]});
      csr_write(CSR_ROW1_B, {m[7], m[6]});
      csr_write(CSR_ROW3_A, {m[9], m[8]});
      csr_write(CSR_ROW3_B, {m[11], m[10]});
      csr_write(CSR_WIDTH, 64'(w));
      csr_write(CSR_HEIGHT, 64'(h));
   endtask

   task automatic drain();
      while (point_q.size() > 0 || req_valid || screen_q.size() > 0) @(posedge clock);
      repeat (PipeLat + 10) @(posedge clock);
   endtask

   function automatic world_pt_type random_point();
      world_pt_type p;
      int z;
      if ($urandom_range(99) < 35) begin
         p = '{$urandom, $urandom, $urandom};
      end else begin
         z = $urandom_range(600, 300 << 16);
         p.z = z;
         p.x = int'($urandom_range(0, 2 * z)) - z;
         p.y = int'($urandom_range(0, 2 * z)) - z;
      end
      return p;
   endfunction

   function automatic logic [31:0] jitter(logic [31:0] base);
      if ($urandom_range(3) == 0) return $urandom;
      return base + int'($urandom_range(0, 1 << 15)) - (1 << 14);
   endfunction

   task automatic random_phase(int n, bit extreme_size);
      logic [31:0] m [12];
      int w, h;
      m = '{One, 0, 0, 0, 0, One, 0, 0, 0, 0, One, 0};
      foreach (m[i]) m[i] = jitter(m[i]);
      w = $urandom_range(1, 8192);
      h = $urandom_range(1, 8192);
      if (extreme_size) begin
         w = ($urandom_range(1)) ? 0 : 16383;
         h = ($urandom_range(1)) ? 8192 : 1;
      end
      load_view(m, w, h);
      repeat (n) point_q.push_back(random_point());
      drain();
   endtask

   initial begin
      logic [31:0] m [12];
      mat_reg = '{default: '0};
      vp_w = 1920;
      vp_h = 1080;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 7;
      recv_idle_pct = 54;

      // reset view: all-zero matrix, nothing visible
      point_q.push_back('{0, 0, 0});
      point_q.push_back('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF});
      drain();

      // plain perspective: threshold, extremes, negative products
      m = '{One, 0, 0, 0, 0, One, 0, 0, 0, 0, One, 0};
      load_view(m, 1920, 1080);
      point_q.push_back('{0, 0, 656});
      point_q.push_back('{0, 0, 655});
      point_q.push_back('{0, 0, 0});
      point_q.push_back('{0, 0, -1});
      point_q.push_back('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 656});
      point_q.push_back('{32'sh8000_0000, 32'sh8000_0000, 656});
      point_q.push_back('{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF});
      point_q.push_back('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF});
      point_q.push_back('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000});
      point_q.push_back('{One, -One, One});
      point_q.push_back('{-1, 1, 3 * One});
      drain();

      // extreme coefficients and sizes: zero width, oversize height, translation
      m = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
            32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h8000_0000,
            32'h0, 32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF};
      load_view(m, 0, 16383);
      point_q.push_back('{0, 0, 0});
      point_q.push_back('{32'sh7FFF_FFFF, -3, 32'sh8000_0000});
      point_q.push_back('{32'sh8000_0000, 32'sh7FFF_FFFF, 5});
      point_q.push_back('{-7, 32'sh8000_0000, 32'sh7FFF_FFFF});
      drain();
      m[10] = 32'h7FFF_FFFF;
      m[11] = 32'h0;
      load_view(m, 8192, 1);
      point_q.push_back('{One, One, 32'sh8000_0000});
      point_q.push_back('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000});
      drain();

      for (int ph = 0; ph < 10; ph++) begin
         if (ph == 4) begin
            send_idle_pct = 54;
            recv_idle_pct = 7;
         end else if (ph == 7) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (ph == 8) begin
            squeeze = 1'b1;
            repeat (400) point_q.push_back(random_point());
            drain();
         end
         random_phase(100, ph == 3 || ph == 9);
      end

      drain();
      repeat (100) @(posedge clock);
      $display("covered %0d result beats (%0d visible) over directed, extreme-size and",
               beats_out, seen_visible);
      $display("random view setups, with both-side stalls and one long output hold-off");
      if (mismatches == 0 && screen_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches, %0d beats missing", mismatches, screen_q.size());
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/wsp_pkg.sv
rtl/core/wsp_dot.sv
rtl/core/wsp_scale.sv
rtl/core/wsp_div.sv
rtl/core/world_to_screen_projection.sv
rtl/core/wsp_checker.sv
sim/tb.sv
